### hdl/kat_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kat_pkg
// Shared constants and codes of the key approval table.
// ----------------------------------------------------------------------------
package kat_pkg;

	localparam int KAT_MAX_KEYS         = 16;
	localparam int KAT_PUBKEY_MAX_BYTES = 65;

	typedef enum logic [2:0] {
		OP_STAGE    = 3'd0,
		OP_ADD      = 3'd1,
		OP_APPROVE  = 3'd2,
		OP_DELETE   = 3'd3,
		OP_GET      = 3'd4,
		OP_IS_OWNER = 3'd5,
		OP_ERASE    = 3'd6,
		OP_NOP      = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_LEN   = 3'd1,
		ST_FULL      = 3'd2,
		ST_DUPLICATE = 3'd3,
		ST_NOT_FOUND = 3'd4,
		ST_TOO_SMALL = 3'd5
	} status_t;

endpackage

### hdl/key_approval_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_approval_table
// Ordered key table with staged public keys, approval marks and owner check.
// ----------------------------------------------------------------------------
// The input channel (in_valid/in_ready) takes one operation item; the output
// channel (out_valid/out_ready) returns its results. Every operation gives
// one result, except a successful get, which gives ceil(len/8) chunk results;
// last marks the final one. Items are handled one at a time: in_ready is high
// only while the sequencer is idle, and an item is taken while a previous
// result still sits in the output register.
// Lookups scan the id memory one entry per cycle. An add then copies the
// staged chunks; a delete moves the later ids (one per cycle) and their
// public key words (one per cycle) down. A get reads each chunk from the
// public key memory before it presents it. Reads of the id and public key
// memories are registered. A stalled receiver holds the output register and
// the sequencer waits for it.
// Reset empties the table at once (count and approval marks are flip-flops);
// memory contents past the count are never read, so no clearing pass runs.
// ----------------------------------------------------------------------------
module key_approval_table
	import kat_pkg::*;
#(
	parameter int MAX_KEYS         = KAT_MAX_KEYS,
	parameter int PUBKEY_MAX_BYTES = KAT_PUBKEY_MAX_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  opcode,
	input  logic [63:0] key_id_high,
	input  logic [63:0] key_id_low,
	input  logic [3:0]  chunk_number,
	input  logic [63:0] chunk_bytes,
	input  logic [6:0]  key_length,
	input  logic [7:0]  buffer_capacity,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic        owner_match,
	output logic [3:0]  out_chunk_number,
	output logic [63:0] out_chunk_bytes,
	output logic [6:0]  out_length,
	output logic [4:0]  approved_count,
	output logic [4:0]  pending_count,
	output logic        last
);

	localparam int NCHUNK = (PUBKEY_MAX_BYTES + 7) / 8;
	localparam int KW     = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
	localparam int CNW    = $clog2(MAX_KEYS + 1);
	localparam int SW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
	localparam int CW     = $clog2(NCHUNK + 1);
	localparam int PKD    = MAX_KEYS * NCHUNK;
	localparam int PKA    = (PKD > 1) ? $clog2(PKD) : 1;
	localparam int PCW    = $clog2(PKD + 1);
	localparam int IDW    = 128 + 7;

	typedef enum logic [9:0] {
		S_IDLE   = 10'b0000000001,
		S_FIND   = 10'b0000000010,
		S_ACOPY  = 10'b0000000100,
		S_DSH_ID = 10'b0000001000,
		S_DSH_PK = 10'b0000010000,
		S_GRD    = 10'b0000100000,
		S_GOUT   = 10'b0001000000,
		S_OWN_RD = 10'b0010000000,
		S_OWN_CM = 10'b0100000000,
		S_RESP   = 10'b1000000000
	} state_t;

	state_t state_q;

	// memories
	logic [IDW-1:0] id_mem [MAX_KEYS];
	logic [63:0]    pk_mem [PKD];
	logic [63:0]    stg_mem [NCHUNK];

	logic           id_ren, id_wen;
	logic [KW-1:0]  id_raddr, id_waddr;
	logic [IDW-1:0] id_wdata, id_rd_s1;
	logic           pk_ren, pk_wen;
	logic [PKA-1:0] pk_raddr, pk_waddr;
	logic [63:0]    pk_wdata, pk_rd_s1;
	logic           stg_ren, stg_wen;
	logic [SW-1:0]  stg_raddr, stg_waddr;
	logic [63:0]    stg_rd_s1;

	// item registers
	op_t         op_q;
	logic [63:0] hi_q, lo_q;
	logic [6:0]  klen_q;
	logic [7:0]  cap_q;

	// table state
	logic [CNW-1:0] count_q, appr_q, pcnt_q;
	logic           pend_q [MAX_KEYS];

	// sequencing
	logic [CNW-1:0] scan_i_q;
	logic           scan_v_s1;
	logic [KW-1:0]  scan_idx_s1;
	logic [CW-1:0]  cp_c_q, cp_c_s1;
	logic           cp_v_s1;
	logic [PCW-1:0] base_q;
	logic [CNW-1:0] sh_src_q;
	logic           sh_v_s1;
	logic [KW-1:0]  sh_dst_s1;
	logic [PCW-1:0] ps_src_q, ps_end_q;
	logic           ps_v_s1;
	logic [PKA-1:0] ps_dst_s1;
	logic [6:0]     glen_q;
	logic [CW-1:0]  gc_q, gn_q;
	status_t        st_q;
	logic           own_q;

	logic           in_acc, slot_free, match, scan_issue, scan_done;
	logic [63:0]    masked;

	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign slot_free = !out_valid || out_ready;

	assign match      = scan_v_s1 && (id_rd_s1[127:0] == {hi_q, lo_q});
	assign scan_issue = !match && (scan_i_q < count_q);
	assign scan_done  = !match && !scan_issue;

	always_comb begin
		for (int b = 0; b < 8; b++) begin
			masked[8*b +: 8] = (int'(gc_q) * 8 + b < int'(glen_q)) ?
				pk_rd_s1[8*b +: 8] : 8'd0;
		end
	end

	// memory port control
	always_comb begin
		id_ren    = 1'b0;
		id_raddr  = '0;
		id_wen    = 1'b0;
		id_waddr  = count_q[KW-1:0];
		id_wdata  = {klen_q, hi_q, lo_q};
		pk_ren    = 1'b0;
		pk_raddr  = '0;
		pk_wen    = 1'b0;
		pk_waddr  = '0;
		pk_wdata  = pk_rd_s1;
		stg_ren   = 1'b0;
		stg_raddr = cp_c_q[SW-1:0];
		stg_wen   = in_acc && (opcode == OP_STAGE) && (int'(chunk_number) < NCHUNK);
		stg_waddr = chunk_number[SW-1:0];
		unique case (state_q)
			S_FIND: begin
				id_ren   = scan_issue;
				id_raddr = scan_i_q[KW-1:0];
				id_wen   = (op_q == OP_ADD) && scan_done;
			end
			S_ACOPY: begin
				stg_ren  = (int'(cp_c_q) < NCHUNK);
				pk_wen   = cp_v_s1;
				pk_waddr = PKA'(base_q + PCW'(cp_c_s1));
				pk_wdata = (int'(cp_c_s1) * 8 < int'(klen_q)) ? stg_rd_s1 : 64'd0;
			end
			S_DSH_ID: begin
				id_ren   = (sh_src_q < count_q);
				id_raddr = sh_src_q[KW-1:0];
				id_wen   = sh_v_s1;
				id_waddr = sh_dst_s1;
				id_wdata = id_rd_s1;
			end
			S_DSH_PK: begin
				pk_ren   = (ps_src_q < ps_end_q);
				pk_raddr = ps_src_q[PKA-1:0];
				pk_wen   = ps_v_s1;
				pk_waddr = ps_dst_s1;
			end
			S_GRD: begin
				pk_ren   = 1'b1;
				pk_raddr = PKA'(base_q + PCW'(gc_q));
			end
			S_OWN_RD: begin
				id_ren = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (id_wen) id_mem[id_waddr] <= id_wdata;
		if (id_ren) id_rd_s1 <= id_mem[id_raddr];
	end

	always_ff @(posedge clk) begin
		if (pk_wen) pk_mem[pk_waddr] <= pk_wdata;
		if (pk_ren) pk_rd_s1 <= pk_mem[pk_raddr];
	end

	always_ff @(posedge clk) begin
		if (stg_wen) stg_mem[stg_waddr] <= chunk_bytes;
		if (stg_ren) stg_rd_s1 <= stg_mem[stg_raddr];
	end

	// item registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q   <= op_t'(opcode);
			hi_q   <= key_id_high;
			lo_q   <= key_id_low;
			klen_q <= key_length;
			cap_q  <= buffer_capacity;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			appr_q    <= '0;
			pcnt_q    <= '0;
			for (int k = 0; k < MAX_KEYS; k++) pend_q[k] <= 1'b0;
			scan_i_q  <= '0;
			scan_v_s1 <= 1'b0;
			cp_v_s1   <= 1'b0;
			sh_v_s1   <= 1'b0;
			ps_v_s1   <= 1'b0;
			out_valid <= 1'b0;
			st_q      <= ST_OK;
			own_q     <= 1'b0;
		end else begin
			if (out_ready && state_q != S_RESP && state_q != S_GOUT) out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						st_q      <= ST_OK;
						own_q     <= 1'b0;
						scan_i_q  <= '0;
						scan_v_s1 <= 1'b0;
						state_q   <= S_RESP;
						case (opcode)
							OP_ADD: begin
								if (key_length == 7'd0 ||
								    int'(key_length) > PUBKEY_MAX_BYTES) begin
									st_q <= ST_BAD_LEN;
								end else if (int'(count_q) >= MAX_KEYS) begin
									st_q <= ST_FULL;
								end else begin
									state_q <= S_FIND;
								end
							end
							OP_APPROVE, OP_DELETE, OP_GET: begin
								state_q <= S_FIND;
							end
							OP_IS_OWNER: begin
								state_q <= S_OWN_RD;
							end
							OP_ERASE: begin
								count_q <= '0;
								appr_q  <= '0;
								pcnt_q  <= '0;
								for (int k = 0; k < MAX_KEYS; k++) pend_q[k] <= 1'b0;
							end
							default: begin
							end
						endcase
					end
				end
				S_FIND: begin
					scan_v_s1   <= scan_issue;
					scan_idx_s1 <= scan_i_q[KW-1:0];
					if (scan_issue) scan_i_q <= scan_i_q + 1'b1;
					if (match) begin
						state_q <= S_RESP;
						case (op_q)
							OP_ADD: st_q <= ST_DUPLICATE;
							OP_APPROVE: begin
								if (pend_q[scan_idx_s1]) begin
									pend_q[scan_idx_s1] <= 1'b0;
									appr_q <= appr_q + 1'b1;
									pcnt_q <= pcnt_q - 1'b1;
								end
							end
							OP_DELETE: begin
								if (pend_q[scan_idx_s1]) pcnt_q <= pcnt_q - 1'b1;
								else appr_q <= appr_q - 1'b1;
								for (int k = 0; k < MAX_KEYS; k++) begin
									if (k >= int'(scan_idx_s1)) begin
										pend_q[k] <= (k + 1 < MAX_KEYS) ? pend_q[(k + 1) % MAX_KEYS]
											: 1'b0;
									end
								end
								sh_src_q <= CNW'(scan_idx_s1) + 1'b1;
								sh_v_s1  <= 1'b0;
								ps_src_q <= PCW'((int'(scan_idx_s1) + 1) * NCHUNK);
								ps_end_q <= PCW'(int'(count_q) * NCHUNK);
								ps_v_s1  <= 1'b0;
								state_q  <= S_DSH_ID;
							end
							OP_GET: begin
								if (pend_q[scan_idx_s1]) begin
									st_q <= ST_NOT_FOUND;
								end else if (cap_q < {1'b0, id_rd_s1[134:128]}) begin
									st_q <= ST_TOO_SMALL;
								end else begin
									glen_q  <= id_rd_s1[134:128];
									base_q  <= PCW'(int'(scan_idx_s1) * NCHUNK);
									gc_q    <= '0;
									gn_q    <= ((int'(id_rd_s1[134:128]) + 7) / 8 > NCHUNK) ?
										CW'(NCHUNK) : CW'((int'(id_rd_s1[134:128]) + 7) / 8);
									state_q <= S_GRD;
								end
							end
							default: begin
							end
						endcase
					end else if (scan_done) begin
						state_q <= S_RESP;
						if (op_q == OP_ADD) begin
							pend_q[count_q[KW-1:0]] <= (count_q != '0);
							if (count_q != '0) pcnt_q <= pcnt_q + 1'b1;
							else appr_q <= appr_q + 1'b1;
							base_q  <= PCW'(int'(count_q) * NCHUNK);
							cp_c_q  <= '0;
							cp_v_s1 <= 1'b0;
							state_q <= S_ACOPY;
						end else begin
							st_q <= ST_NOT_FOUND;
						end
					end
				end
				S_ACOPY: begin
					cp_v_s1 <= (int'(cp_c_q) < NCHUNK);
					cp_c_s1 <= cp_c_q;
					if (int'(cp_c_q) < NCHUNK) begin
						cp_c_q <= cp_c_q + 1'b1;
					end else if (cp_v_s1) begin
						count_q <= count_q + 1'b1;
						state_q <= S_RESP;
					end
				end
				S_DSH_ID: begin
					sh_v_s1   <= (sh_src_q < count_q);
					sh_dst_s1 <= KW'(sh_src_q - 1'b1);
					if (sh_src_q < count_q) sh_src_q <= sh_src_q + 1'b1;
					else if (!sh_v_s1) state_q <= S_DSH_PK;
				end
				S_DSH_PK: begin
					ps_v_s1   <= (ps_src_q < ps_end_q);
					ps_dst_s1 <= PKA'(ps_src_q - PCW'(NCHUNK));
					if (ps_src_q < ps_end_q) begin
						ps_src_q <= ps_src_q + 1'b1;
					end else if (!ps_v_s1) begin
						count_q <= count_q - 1'b1;
						state_q <= S_RESP;
					end
				end
				S_GRD: begin
					state_q <= S_GOUT;
				end
				S_GOUT: begin
					if (slot_free) begin
						out_valid        <= 1'b1;
						status           <= ST_OK;
						owner_match      <= 1'b0;
						out_chunk_number <= 4'(gc_q);
						out_chunk_bytes  <= masked;
						out_length       <= glen_q;
						approved_count   <= 5'(appr_q);
						pending_count    <= 5'(pcnt_q);
						last             <= (gc_q + 1'b1 == gn_q);
						if (gc_q + 1'b1 == gn_q) begin
							state_q <= S_IDLE;
						end else begin
							gc_q    <= gc_q + 1'b1;
							state_q <= S_GRD;
						end
					end
				end
				S_OWN_RD: begin
					state_q <= S_OWN_CM;
				end
				S_OWN_CM: begin
					own_q   <= (count_q != '0) && (id_rd_s1[127:0] == {hi_q, lo_q}) &&
						!pend_q[0];
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (slot_free) begin
						out_valid        <= 1'b1;
						status           <= st_q;
						owner_match      <= own_q;
						out_chunk_number <= 4'd0;
						out_chunk_bytes  <= 64'd0;
						out_length       <= 7'd0;
						approved_count   <= 5'(appr_q);
						pending_count    <= 5'(pcnt_q);
						last             <= 1'b1;
						state_q          <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_counts_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (appr_q + pcnt_q == count_q))
		else $error("approved and pending counts do not add up to the entry count");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		int'(count_q) <= MAX_KEYS)
		else $error("entry count beyond table size");

	a_owner_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && owner_match) |-> (status == ST_OK && last))
		else $error("owner answer on a failing or partial result");

	a_resp_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESP && out_valid && !out_ready) |=> (state_q == S_RESP))
		else $error("result dropped while the receiver stalls");

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the key approval table: directed passes over every opcode,
// error path and back-pressure, then random operation mixes with idling on
// both sides. Each result is compared field by field with a predicted table.
// ----------------------------------------------------------------------------
module tb_top;
	import kat_pkg::*;

	localparam int NCH = (KAT_PUBKEY_MAX_BYTES + 7) / 8;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [2:0]  st;
		logic        own;
		logic [3:0]  cnum;
		logic [63:0] bytes;
		logic [6:0]  len;
		logic [4:0]  appr;
		logic [4:0]  pend;
		logic        lst;
	} kat_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] opcode = '0;
	logic [63:0] key_id_high = '0, key_id_low = '0, chunk_bytes = '0;
	logic [3:0] chunk_number = '0;
	logic [6:0] key_length = '0;
	logic [7:0] buffer_capacity = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [2:0] status;
	logic owner_match;
	logic [3:0] out_chunk_number;
	logic [63:0] out_chunk_bytes;
	logic [6:0] out_length;
	logic [4:0] approved_count, pending_count;
	logic last;

	key_approval_table dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// predicted table
	logic [127:0] tbl_id [KAT_MAX_KEYS];
	logic [63:0] tbl_key [KAT_MAX_KEYS][NCH];
	int unsigned tbl_len [KAT_MAX_KEYS];
	bit tbl_pend [KAT_MAX_KEYS];
	int unsigned tbl_count;
	logic [63:0] staged [NCH];
	bit staged_ok [NCH];

	kat_result_t expected_results [$];
	int errors = 0;
	int results_seen = 0;
	int items_sent = 0;
	bit in_idle_on = 1'b1, out_idle_on = 1'b1;
	int out_hold = 0;
	int cycles = 0;
	int op_hits [8];

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] exp);
		errors++;
		$display("mismatch at result %0d: %s got %0h expected %0h", results_seen, what,
			got, exp);
	endtask

	function automatic int find_id(input logic [127:0] id);
		for (int i = 0; i < tbl_count; i++)
			if (tbl_id[i] == id) return i;
		return -1;
	endfunction

	function automatic void push_result(input status_t st, input bit own,
			input int cn, input logic [63:0] b, input int ln, input bit lst);
		kat_result_t r;
		int a, p;
		a = 0;
		p = 0;
		for (int i = 0; i < tbl_count; i++)
			if (tbl_pend[i]) p++; else a++;
		r.st = st; r.own = own; r.cnum = 4'(cn); r.bytes = b; r.len = 7'(ln);
		r.appr = 5'(a); r.pend = 5'(p); r.lst = lst;
		expected_results.push_back(r);
	endfunction

	function automatic void predict_table_op(input op_t op, input logic [127:0] id,
			input int cn, input logic [63:0] cb, input int klen, input int cap);
		int idx, n, rem;
		logic [63:0] b;
		status_t st;
		bit own;
		st = ST_OK;
		own = 1'b0;
		op_hits[op]++;
		case (op)
		OP_STAGE: begin
			if (cn < NCH) begin
				staged[cn] = cb;
				staged_ok[cn] = 1'b1;
			end
		end
		OP_ADD: begin
			if (klen == 0 || klen > KAT_PUBKEY_MAX_BYTES) st = ST_BAD_LEN;
			else if (tbl_count >= KAT_MAX_KEYS) st = ST_FULL;
			else if (find_id(id) >= 0) st = ST_DUPLICATE;
			else begin
				tbl_id[tbl_count] = id;
				tbl_len[tbl_count] = klen;
				for (int c = 0; c < NCH; c++)
					tbl_key[tbl_count][c] = (c * 8 < klen) ? staged[c] : '0;
				tbl_pend[tbl_count] = (tbl_count != 0);
				tbl_count++;
			end
		end
		OP_APPROVE: begin
			idx = find_id(id);
			if (idx < 0) st = ST_NOT_FOUND;
			else tbl_pend[idx] = 1'b0;
		end
		OP_DELETE: begin
			idx = find_id(id);
			if (idx < 0) st = ST_NOT_FOUND;
			else begin
				for (int j = idx; j + 1 < tbl_count; j++) begin
					tbl_id[j] = tbl_id[j + 1];
					tbl_len[j] = tbl_len[j + 1];
					tbl_pend[j] = tbl_pend[j + 1];
					tbl_key[j] = tbl_key[j + 1];
				end
				tbl_count--;
			end
		end
		OP_GET: begin
			idx = find_id(id);
			if (idx < 0 || tbl_pend[idx]) st = ST_NOT_FOUND;
			else if (cap < tbl_len[idx]) st = ST_TOO_SMALL;
			else begin
				n = (tbl_len[idx] + 7) / 8;
				for (int c = 0; c < n; c++) begin
					b = tbl_key[idx][c];
					rem = tbl_len[idx] - c * 8;
					if (rem < 8) b &= (64'd1 << (8 * rem)) - 64'd1;
					push_result(ST_OK, 1'b0, c, b, tbl_len[idx], c + 1 == n);
				end
				return;
			end
		end
		OP_IS_OWNER: own = tbl_count > 0 && tbl_id[0] == id && !tbl_pend[0];
		OP_ERASE: tbl_count = 0;
		default: ;
		endcase
		push_result(st, own, 0, '0, 0, 1'b1);
	endfunction

	task automatic send_item(input op_t op, input logic [127:0] id, input int cn,
			input logic [63:0] cb, input int klen, input int cap);
		// an add must never copy chunks staged nowhere
		if (op == OP_ADD)
			for (int c = 0; c < NCH; c++)
				if (c * 8 < klen && klen <= KAT_PUBKEY_MAX_BYTES && !staged_ok[c])
					klen = c * 8 == 0 ? 0 : c * 8;
		@(negedge clk);
		while (in_idle_on && $urandom_range(99) < 19) @(negedge clk);
		opcode <= op;
		{key_id_high, key_id_low} <= id;
		chunk_number <= 4'(cn);
		chunk_bytes <= cb;
		key_length <= 7'(klen);
		buffer_capacity <= 8'(cap);
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_table_op(op, id, cn, cb, klen, cap);
		items_sent++;
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic stage_all();
		for (int c = 0; c < NCH; c++)
			send_item(OP_STAGE, '0, c, {$urandom, $urandom}, 0, 0);
	endtask

	function automatic logic [127:0] rand_id();
		return {$urandom, $urandom, $urandom, $urandom};
	endfunction

	task automatic wait_drained();
		while (expected_results.size() != 0) @(negedge clk);
		repeat (80) @(negedge clk);
	endtask

	// checker
	always @(posedge clk) begin
		kat_result_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				errors++;
				$display("unexpected result, status %0d", status);
			end else begin
				e = expected_results.pop_front();
				if (status !== e.st) report_mismatch("status", status, e.st);
				if (owner_match !== e.own) report_mismatch("owner_match", owner_match, e.own);
				if (out_chunk_number !== e.cnum)
					report_mismatch("out_chunk_number", out_chunk_number, e.cnum);
				if (out_chunk_bytes !== e.bytes)
					report_mismatch("out_chunk_bytes", out_chunk_bytes, e.bytes);
				if (out_length !== e.len) report_mismatch("out_length", out_length, e.len);
				if (approved_count !== e.appr)
					report_mismatch("approved_count", approved_count, e.appr);
				if (pending_count !== e.pend)
					report_mismatch("pending_count", pending_count, e.pend);
				if (last !== e.lst) report_mismatch("last", last, e.lst);
			end
			results_seen++;
		end
	end

	// receiver
	always @(negedge clk) begin
		if (out_hold > 0) begin
			out_hold--;
			out_ready <= 1'b0;
		end else
			out_ready <= !(out_idle_on && $urandom_range(99) < 19);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("tb_top: errors");
			$finish;
		end
	end

	task automatic test_directed();
		logic [127:0] a, b, c;
		a = '1;
		b = '0;
		c = rand_id();
		send_item(OP_STAGE, '0, 0, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0);
		for (int k = 1; k < NCH; k++) send_item(OP_STAGE, '0, k, {$urandom, $urandom}, 0, 0);
		send_item(OP_STAGE, '0, 15, '1, 0, 0);
		send_item(OP_ADD, a, 0, '0, 0, 0);
		send_item(OP_ADD, a, 0, '0, 66, 0);
		send_item(OP_ADD, a, 0, '0, 127, 0);
		send_item(OP_IS_OWNER, a, 0, '0, 0, 0);
		send_item(OP_ADD, a, 0, '0, 65, 0);
		send_item(OP_ADD, a, 0, '0, 1, 0);
		send_item(OP_ADD, b, 0, '0, 1, 0);
		send_item(OP_GET, b, 0, '0, 0, 255);
		send_item(OP_GET, a, 0, '0, 0, 64);
		send_item(OP_GET, a, 0, '0, 0, 65);
		send_item(OP_IS_OWNER, a, 0, '0, 0, 0);
		send_item(OP_IS_OWNER, b, 0, '0, 0, 0);
		send_item(OP_APPROVE, c, 0, '0, 0, 0);
		send_item(OP_APPROVE, b, 0, '0, 0, 0);
		send_item(OP_APPROVE, a, 0, '0, 0, 0);
		send_item(OP_GET, b, 0, '0, 0, 1);
		send_item(OP_DELETE, c, 0, '0, 0, 0);
		send_item(OP_DELETE, a, 0, '0, 0, 0);
		send_item(OP_IS_OWNER, b, 0, '0, 0, 0);
		send_item(OP_NOP, '0, 0, '0, 0, 0);
		send_item(OP_ERASE, '0, 0, '0, 0, 0);
	endtask

	task automatic test_full_table();
		for (int i = 0; i <= KAT_MAX_KEYS; i++)
			send_item(OP_ADD, rand_id(), 0, '0, $urandom_range(1, 65), 0);
		send_item(OP_ERASE, '0, 0, '0, 0, 0);
	endtask

	task automatic test_backpressure();
		out_hold = 300;
		out_idle_on = 1'b0;
		for (int i = 0; i < 6; i++) send_item(OP_STAGE, '0, i, {$urandom, $urandom}, 0, 0);
		send_item(OP_ADD, rand_id(), 0, '0, 65, 0);
		send_item(OP_GET, tbl_id[0], 0, '0, 0, 255);
		wait_drained();
		out_idle_on = 1'b1;
	endtask

	task automatic test_random_ops();
		logic [127:0] id;
		int r;
		for (int i = 0; i < 160; i++) begin
			if (i == 80) begin
				in_idle_on = 1'b0;
				out_idle_on = 1'b0;
			end
			if (i == 130) begin
				in_idle_on = 1'b1;
				out_idle_on = 1'b1;
			end
			r = $urandom_range(99);
			id = (tbl_count > 0 && $urandom_range(3) != 0) ?
				tbl_id[$urandom_range(tbl_count - 1)] : rand_id();
			if (r < 15)
				send_item(OP_STAGE, '0, $urandom_range(15), {$urandom, $urandom}, 0, 0);
			else if (r < 35)
				send_item(OP_ADD, id, 0, '0,
					$urandom_range(9) == 0 ? $urandom_range(127) : $urandom_range(1, 65), 0);
			else if (r < 50) send_item(OP_APPROVE, id, 0, '0, 0, 0);
			else if (r < 60) send_item(OP_DELETE, id, 0, '0, 0, 0);
			else if (r < 82) send_item(OP_GET, id, 0, '0, 0,
				$urandom_range(3) == 0 ? $urandom_range(255) : 255);
			else if (r < 92) send_item(OP_IS_OWNER, $urandom_range(1) ? tbl_id[0] : id,
				0, '0, 0, 0);
			else if (r < 96) send_item(OP_ERASE, '0, 0, '0, 0, 0);
			else send_item(OP_NOP, rand_id(), $urandom_range(15), {$urandom, $urandom},
				$urandom_range(127), $urandom_range(255));
		end
	endtask

	initial begin
		for (int i = 0; i < NCH; i++) staged_ok[i] = 1'b0;
		tbl_count = 0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_full_table();
		test_backpressure();
		stage_all();
		test_random_ops();
		wait_drained();
		$display("ran %0d items and checked %0d results", items_sent, results_seen);
		$display("ops: stage %0d add %0d approve %0d delete %0d get %0d owner %0d erase %0d",
			op_hits[0], op_hits[1], op_hits[2], op_hits[3], op_hits[4], op_hits[5],
			op_hits[6]);
		if (errors == 0 && expected_results.size() == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule

### filelist.f
hdl/kat_pkg.sv
hdl/key_approval_table.sv
dv/tb_top.sv
